### hw/rtl/lzs_pkg.sv
`timescale 1ns / 1ps

package lzs_pkg;

  // Sine table geometry: one full turn of 65536 binary angle units.
  localparam int SinDepth = 1024;
  localparam int SinIdxW  = $clog2(SinDepth);
  localparam int SinW     = 17;

  localparam int AngleW = 16;
  localparam int RangeW = 16;
  localparam int ProdW  = RangeW + SinW + 1;
  localparam int FrontW = 18;
  localparam int SideW  = 17;
  localparam int GainW  = 10;
  localparam int RateW  = 10;
  localparam int TurnW  = 11;
  localparam int SpeedW = 16;

  localparam logic [AngleW-1:0]        QuarterTurn  = 16'h4000;
  localparam logic signed [FrontW-1:0] FrontNone    = 18'sd65536;
  localparam logic [SideW-1:0]         SideNone     = 17'd65536;
  localparam logic [SideW:0]           TurnMargin   = 18'd100;
  localparam logic signed [SpeedW-1:0] DefaultSpeed = 16'sd1000;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef logic signed [SinW-1:0] sin_t;
  typedef sin_t sin_tab_t [SinDepth];

  typedef enum logic [2:0] {
    RegAngleStart    = 3'd0,
    RegAngleStep     = 3'd1,
    RegFrontHalfWdt  = 3'd2,
    RegSideMinFwd    = 3'd3,
    RegSlowDistance  = 3'd4,
    RegStopOffset    = 3'd5,
    RegSlowGain      = 3'd6,
    RegTurnRate      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]      angle_start;
    logic [15:0]      angle_step;
    logic [15:0]      front_half_width;
    logic [15:0]      side_min_forward;
    logic [15:0]      slow_distance;
    logic [15:0]      stop_offset;
    logic [GainW-1:0] slow_gain;
    logic [RateW-1:0] turn_rate;
  } cfg_t;

  // Zone minima of one finished scan.
  typedef struct packed {
    logic signed [FrontW-1:0] front;
    logic [SideW-1:0]         left;
    logic [SideW-1:0]         right;
  } scan_t;

  // Q15 sine of a binary angle by a Taylor series on the first quadrant.
  // Only evaluated at elaboration to build the ROM contents.
  function automatic sin_t sine_q15(input logic [AngleW-1:0] a);
    longint unsigned r;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned term;
    longint          sum;
    longint          res;
    logic [1:0]      q;
    q = a[15:14];
    r = 64'(a[13:0]);
    if (q[0]) begin
      r = 64'd16384 - r;
    end
    z    = (r * HalfPiQ30) >> 14;
    z2   = (z * z) >> 30;
    term = z;
    sum  = $signed(z);
    term = ((term * z2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * z2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * z2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * z2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * z2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * z2) >> 30) / 156;
    sum  = sum + $signed(term);
    term = ((term * z2) >> 30) / 210;
    sum  = sum - $signed(term);
    term = ((term * z2) >> 30) / 272;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    res = (sum + 64'sd16384) >>> 15;
    if (res > 64'sd32768) begin
      res = 64'sd32768;
    end
    return q[1] ? -sin_t'(SinW'(res)) : sin_t'(SinW'(res));
  endfunction

  function automatic sin_tab_t build_sin_table();
    sin_tab_t tab;
    for (int k = 0; k < SinDepth; k++) begin
      tab[k] = sine_q15(AngleW'(k * (65536 / SinDepth)));
    end
    return tab;
  endfunction

endpackage

### hw/rtl/lzs_sine_rom.sv
`timescale 1ns / 1ps

module lzs_sine_rom (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lzs_pkg::SinIdxW-1:0]  addr_a_i,
  input  logic [lzs_pkg::SinIdxW-1:0]  addr_b_i,
  output lzs_pkg::sin_t                data_a_o,
  output lzs_pkg::sin_t                data_b_o
);
  import lzs_pkg::*;

  localparam sin_tab_t SinRom = build_sin_table();

  sin_t data_a_q;
  sin_t data_b_q;

  // Two registered read ports; data holds while the enable is low.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SinRom[addr_a_i];
      data_b_q <= SinRom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

### hw/rtl/lzs_zone_track.sv
`timescale 1ns / 1ps

module lzs_zone_track (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lzs_pkg::cfg_t               cfg_i,
  input  logic                        s1_valid_i,
  input  logic [lzs_pkg::RangeW-1:0]  s1_range_i,
  input  logic                        s1_last_i,
  input  lzs_pkg::sin_t               s1_sin_i,
  input  lzs_pkg::sin_t               s1_cos_i,
  output logic                        s1_ready_o,
  output logic                        scan_valid_o,
  output lzs_pkg::scan_t              scan_o,
  input  logic                        scan_ready_i
);
  import lzs_pkg::*;

  // Product stage.
  logic                     valid2_q;
  logic                     last2_q;
  logic [RangeW-1:0]        range2_q;
  logic signed [ProdW-1:0]  xp2_q;
  logic signed [ProdW-1:0]  yp2_q;

  // Running minima of the current scan.
  logic signed [FrontW-1:0] front_q, front_d;
  logic [SideW-1:0]         left_q, left_d;
  logic [SideW-1:0]         right_q, right_d;

  // Finished scan waiting for the steering stage.
  logic                     valid3_q;
  scan_t                    scan3_q;

  logic                     ready2;
  logic                     ready3;
  logic                     fire2;
  logic signed [ProdW-1:0]  half_w;
  logic signed [ProdW-1:0]  side_fwd;
  logic signed [ProdW-1:0]  y_round;
  logic signed [FrontW-1:0] y_mm;
  logic                     in_front;
  logic                     in_side;

  assign ready3 = !valid3_q || scan_ready_i;
  // Items that do not close a scan leave the product stage without a slot downstream.
  assign ready2 = !valid2_q || !last2_q || ready3;
  assign fire2  = valid2_q && (!last2_q || ready3);
  assign s1_ready_o = ready2;

  assign half_w   = $signed({3'b000, cfg_i.front_half_width, 15'd0});
  assign side_fwd = $signed({3'b000, cfg_i.side_min_forward, 15'd0});
  assign y_round  = yp2_q + $signed(ProdW'(1 << 14));
  assign y_mm     = FrontW'(y_round >>> 15);
  assign in_front = (xp2_q > -half_w) && (xp2_q < half_w);
  assign in_side  = yp2_q > side_fwd;

  always_comb begin
    front_d = front_q;
    left_d  = left_q;
    right_d = right_q;
    if (in_front && (y_mm < front_q)) begin
      front_d = y_mm;
    end
    if (in_side && (xp2_q > 0) && ({1'b0, range2_q} < right_q)) begin
      right_d = {1'b0, range2_q};
    end
    if (in_side && (xp2_q < 0) && ({1'b0, range2_q} < left_q)) begin
      left_d = {1'b0, range2_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      front_q  <= FrontNone;
      left_q   <= SideNone;
      right_q  <= SideNone;
    end else begin
      if (ready2) begin
        valid2_q <= s1_valid_i;
      end
      if (fire2) begin
        if (last2_q) begin
          front_q <= FrontNone;
          left_q  <= SideNone;
          right_q <= SideNone;
        end else begin
          front_q <= front_d;
          left_q  <= left_d;
          right_q <= right_d;
        end
      end
      if (ready3) begin
        valid3_q <= fire2 && last2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && s1_valid_i) begin
      last2_q  <= s1_last_i;
      range2_q <= s1_range_i;
      xp2_q    <= $signed({1'b0, s1_range_i}) * s1_sin_i;
      yp2_q    <= $signed({1'b0, s1_range_i}) * s1_cos_i;
    end
    if (fire2 && last2_q) begin
      scan3_q.front <= front_d;
      scan3_q.left  <= left_d;
      scan3_q.right <= right_d;
    end
  end

  assign scan_valid_o = valid3_q;
  assign scan_o       = scan3_q;

endmodule

### hw/rtl/lzs_steer.sv
`timescale 1ns / 1ps

module lzs_steer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lzs_pkg::cfg_t                     cfg_i,
  input  logic                              scan_valid_i,
  input  lzs_pkg::scan_t                    scan_i,
  output logic                              scan_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lzs_pkg::FrontW-1:0] front_distance_o,
  output logic [lzs_pkg::SideW-1:0]         left_gap_o,
  output logic [lzs_pkg::SideW-1:0]         right_gap_o,
  output logic signed [lzs_pkg::SpeedW-1:0] linear_speed_o,
  output logic signed [lzs_pkg::TurnW-1:0]  angular_rate_o
);
  import lzs_pkg::*;

  localparam int DiffW = FrontW + 1;
  localparam int MulW  = DiffW + GainW + 1;

  logic                     valid4_q;
  scan_t                    scan4_q;
  logic signed [MulW-1:0]   prod4_q;
  logic                     slow4_q;
  logic signed [TurnW-1:0]  turn4_q;

  logic                     out_valid_q;
  scan_t                    out_scan_q;
  logic signed [SpeedW-1:0] speed_q;
  logic signed [TurnW-1:0]  turn_q;

  logic                     ready_out;
  logic                     ready4;
  logic signed [DiffW-1:0]  diff;
  logic                     slow;
  logic [SideW:0]           left_m;
  logic [SideW:0]           right_m;
  logic signed [TurnW-1:0]  rate;
  logic signed [TurnW-1:0]  turn;
  logic signed [MulW:0]     rounded;
  logic signed [MulW-10:0]  scaled;
  logic signed [SpeedW-1:0] speed;

  assign ready_out = !out_valid_q || out_ready_i;
  assign ready4    = !valid4_q || ready_out;
  assign scan_ready_o = ready4;

  assign diff = $signed({scan_i.front[FrontW-1], scan_i.front})
              - $signed({3'b000, cfg_i.stop_offset});
  assign slow = scan_i.front < $signed({2'b00, cfg_i.slow_distance});

  // The right-side test wins when both sides are within the margin.
  assign left_m  = {1'b0, scan_i.left} + TurnMargin;
  assign right_m = {1'b0, scan_i.right} + TurnMargin;
  assign rate    = $signed({1'b0, cfg_i.turn_rate});
  always_comb begin
    turn = '0;
    if ({1'b0, scan_i.right} < left_m) begin
      turn = -rate;
    end else if ({1'b0, scan_i.left} < right_m) begin
      turn = rate;
    end
  end

  assign rounded = {prod4_q[MulW-1], prod4_q} + $signed((MulW + 1)'(512));
  assign scaled  = (MulW - 9)'(rounded >>> 10);
  always_comb begin
    speed = DefaultSpeed;
    if (slow4_q) begin
      if (scaled > $signed((MulW - 9)'(32767))) begin
        speed = 16'sh7fff;
      end else if (scaled < -$signed((MulW - 9)'(32768))) begin
        speed = 16'sh8000;
      end else begin
        speed = SpeedW'(scaled);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready4) begin
        valid4_q <= scan_valid_i;
      end
      if (ready_out) begin
        out_valid_q <= valid4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && scan_valid_i) begin
      scan4_q <= scan_i;
      prod4_q <= $signed({1'b0, cfg_i.slow_gain}) * diff;
      slow4_q <= slow;
      turn4_q <= turn;
    end
    if (ready_out && valid4_q) begin
      out_scan_q <= scan4_q;
      speed_q    <= speed;
      turn_q     <= turn4_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign front_distance_o = out_scan_q.front;
  assign left_gap_o       = out_scan_q.left;
  assign right_gap_o      = out_scan_q.right;
  assign linear_speed_o   = speed_q;
  assign angular_rate_o   = turn_q;

endmodule

### hw/rtl/lidar_zone_steering.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_i     range_mm_i, last_of_scan_i
// out       output     out_valid_o / out_ready_i   front_distance_o, left_gap_o, right_gap_o,
//                                                  linear_speed_o, angular_rate_o
// cfg       input      cfg_we_i (no wait)          cfg_idx_i, cfg_wdata_i
//
// One sample is accepted per cycle while in_ready_o is high. After its last
// sample is accepted, a scan result passes the ROM read, multiply, minima
// update and gain multiply registers, then is rounded and saturated into
// the output register. Reset returns the valid bits, configuration, angle
// and minima registers to their reset values. Only untaken scan results
// back up the pipe; ordinary samples drain past them, so the input stalls
// only when three untaken results fill the output, steering and scan
// registers and the next scan's last sample waits behind them.

module lidar_zone_steering (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lzs_pkg::RangeW-1:0]        range_mm_i,
  input  logic                              last_of_scan_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lzs_pkg::FrontW-1:0] front_distance_o,
  output logic [lzs_pkg::SideW-1:0]         left_gap_o,
  output logic [lzs_pkg::SideW-1:0]         right_gap_o,
  output logic signed [lzs_pkg::SpeedW-1:0] linear_speed_o,
  output logic signed [lzs_pkg::TurnW-1:0]  angular_rate_o
);
  import lzs_pkg::*;

  cfg_t               cfg_q;
  logic [AngleW-1:0]  angle_q;

  // Input stage: the sample and its sine/cosine read from the ROM.
  logic               valid1_q;
  logic [RangeW-1:0]  range1_q;
  logic               last1_q;
  sin_t               sin1;
  sin_t               cos1;

  logic               ready1;
  logic               ready2;
  logic               accept;
  logic [AngleW-1:0]  cos_angle;
  logic               scan_valid;
  logic               scan_ready;
  scan_t              scan;

  assign ready1     = !valid1_q || ready2;
  assign in_ready_o = ready1;
  assign accept     = in_valid_i && ready1;
  assign cos_angle  = angle_q + QuarterTurn;

  // Configuration registers. Writing the start angle also restarts the
  // angle sequence; a scan's end reloads it from the start angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_start      <= 16'd0;
      cfg_q.angle_step       <= 16'd0;
      cfg_q.front_half_width <= 16'd300;
      cfg_q.side_min_forward <= 16'd250;
      cfg_q.slow_distance    <= 16'd750;
      cfg_q.stop_offset      <= 16'd350;
      cfg_q.slow_gain        <= 10'd819;
      cfg_q.turn_rate        <= 10'd400;
      angle_q                <= '0;
      valid1_q               <= 1'b0;
    end else begin
      if (accept) begin
        angle_q <= last_of_scan_i ? cfg_q.angle_start : angle_q + cfg_q.angle_step;
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegAngleStart: begin
            cfg_q.angle_start <= cfg_wdata_i;
            angle_q           <= cfg_wdata_i;
          end
          RegAngleStep:    cfg_q.angle_step       <= cfg_wdata_i;
          RegFrontHalfWdt: cfg_q.front_half_width <= cfg_wdata_i;
          RegSideMinFwd:   cfg_q.side_min_forward <= cfg_wdata_i;
          RegSlowDistance: cfg_q.slow_distance    <= cfg_wdata_i;
          RegStopOffset:   cfg_q.stop_offset      <= cfg_wdata_i;
          RegSlowGain:     cfg_q.slow_gain        <= cfg_wdata_i[GainW-1:0];
          RegTurnRate:     cfg_q.turn_rate        <= cfg_wdata_i[RateW-1:0];
          default: begin
          end
        endcase
      end
      if (ready1) begin
        valid1_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      range1_q <= range_mm_i;
      last1_q  <= last_of_scan_i;
    end
  end

  // The table index is the top bits of the binary angle.
  lzs_sine_rom u_rom (
    .clk_i    (clk_i),
    .en_i     (accept),
    .addr_a_i (angle_q[AngleW-1 -: SinIdxW]),
    .addr_b_i (cos_angle[AngleW-1 -: SinIdxW]),
    .data_a_o (sin1),
    .data_b_o (cos1)
  );

  lzs_zone_track u_zone (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s1_valid_i   (valid1_q),
    .s1_range_i   (range1_q),
    .s1_last_i    (last1_q),
    .s1_sin_i     (sin1),
    .s1_cos_i     (cos1),
    .s1_ready_o   (ready2),
    .scan_valid_o (scan_valid),
    .scan_o       (scan),
    .scan_ready_i (scan_ready)
  );

  lzs_steer u_steer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .scan_valid_i     (scan_valid),
    .scan_i           (scan),
    .scan_ready_o     (scan_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .front_distance_o (front_distance_o),
    .left_gap_o       (left_gap_o),
    .right_gap_o      (right_gap_o),
    .linear_speed_o   (linear_speed_o),
    .angular_rate_o   (angular_rate_o)
  );

endmodule

### test/lidar_zone_steering_check.sv
`timescale 1ns / 1ps

module lidar_zone_steering_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [15:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [lzs_pkg::RangeW-1:0]        range_mm_i,
  input  logic                              last_of_scan_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [lzs_pkg::FrontW-1:0] front_distance_i,
  input  logic [lzs_pkg::SideW-1:0]         left_gap_i,
  input  logic [lzs_pkg::SideW-1:0]         right_gap_i,
  input  logic signed [lzs_pkg::SpeedW-1:0] linear_speed_i,
  input  logic signed [lzs_pkg::TurnW-1:0]  angular_rate_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                results_o
);
  import lzs_pkg::*;

  localparam longint unsigned PiOver2Q30 = 64'd1686629713;
  localparam longint NoZone      = 65536;
  localparam longint SideMargin  = 100;
  localparam longint CruiseSpeed = 1000;

  typedef struct {
    logic signed [FrontW-1:0] front;
    logic [SideW-1:0]         left;
    logic [SideW-1:0]         right;
    logic signed [SpeedW-1:0] speed;
    logic signed [TurnW-1:0]  turn;
  } steer_t;

  steer_t      steer_q[$];
  int          sine_lut[SinDepth];
  cfg_t        regs;
  logic [15:0] heading;
  longint      front_min;
  longint      left_min;
  longint      right_min;

  // Q15 sine over one full turn, a first-quadrant Taylor series folded by quadrant.
  initial begin : build_lut
    longint unsigned a;
    longint unsigned rem;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned term;
    longint          sum;
    longint          res;
    for (int k = 0; k < SinDepth; k++) begin
      a   = (longint'(k) * 65536) / SinDepth;
      rem = a & 64'h3FFF;
      if (a[14]) begin
        rem = 64'd16384 - rem;
      end
      z    = (rem * PiOver2Q30) >> 14;
      z2   = (z * z) >> 30;
      term = z;
      sum  = longint'(z);
      for (int n = 1; n <= 8; n++) begin
        term = (term * z2) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      res = (sum + 16384) >>> 15;
      if (res > 32768) begin
        res = 32768;
      end
      sine_lut[k] = a[15] ? -int'(res) : int'(res);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint      r;
    longint      xp;
    longint      yp;
    longint      hw;
    longint      ym;
    longint      spd;
    longint      trn;
    logic [15:0] fwd_ang;
    steer_t      want;
    if (!rst_ni) begin
      regs.angle_start      = 16'd0;
      regs.angle_step       = 16'd0;
      regs.front_half_width = 16'd300;
      regs.side_min_forward = 16'd250;
      regs.slow_distance    = 16'd750;
      regs.stop_offset      = 16'd350;
      regs.slow_gain        = 10'd819;
      regs.turn_rate        = 10'd400;
      heading   = 16'd0;
      front_min = NoZone;
      left_min  = NoZone;
      right_min = NoZone;
      steer_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegAngleStart: begin
            regs.angle_start = cfg_wdata_i;
            heading          = cfg_wdata_i;
          end
          RegAngleStep:    regs.angle_step       = cfg_wdata_i;
          RegFrontHalfWdt: regs.front_half_width = cfg_wdata_i;
          RegSideMinFwd:   regs.side_min_forward = cfg_wdata_i;
          RegSlowDistance: regs.slow_distance    = cfg_wdata_i;
          RegStopOffset:   regs.stop_offset      = cfg_wdata_i;
          RegSlowGain:     regs.slow_gain        = cfg_wdata_i[GainW-1:0];
          RegTurnRate:     regs.turn_rate        = cfg_wdata_i[RateW-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        fwd_ang = heading + QuarterTurn;
        r  = longint'(range_mm_i);
        xp = r * longint'(sine_lut[(int'(heading) * SinDepth) >> 16]);
        yp = r * longint'(sine_lut[(int'(fwd_ang) * SinDepth) >> 16]);
        hw = longint'(regs.front_half_width) << 15;
        if (xp > -hw && xp < hw) begin
          ym = (yp + 16384) >>> 15;
          if (ym < front_min) begin
            front_min = ym;
          end
        end
        if (yp > (longint'(regs.side_min_forward) << 15)) begin
          if (xp > 0 && r < right_min) begin
            right_min = r;
          end
          if (xp < 0 && r < left_min) begin
            left_min = r;
          end
        end
        heading = heading + regs.angle_step;

        if (last_of_scan_i) begin
          spd = CruiseSpeed;
          if (front_min < longint'(regs.slow_distance)) begin
            spd = (longint'(regs.slow_gain) * (front_min - longint'(regs.stop_offset))
                   + 512) >>> 10;
            if (spd > 32767) begin
              spd = 32767;
            end
            if (spd < -32768) begin
              spd = -32768;
            end
          end
          // Turning away from the nearer side; the right-hand test wins a tie.
          trn = 0;
          if (left_min < right_min + SideMargin) begin
            trn = longint'(regs.turn_rate);
          end
          if (right_min < left_min + SideMargin) begin
            trn = -longint'(regs.turn_rate);
          end
          want.front = FrontW'(front_min);
          want.left  = SideW'(left_min);
          want.right = SideW'(right_min);
          want.speed = SpeedW'(spd);
          want.turn  = TurnW'(trn);
          steer_q.push_back(want);
          front_min = NoZone;
          left_min  = NoZone;
          right_min = NoZone;
          heading   = regs.angle_start;
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (steer_q.size() == 0) begin
          $error("scan result with no scan closed: front %0d left %0d right %0d",
                 front_distance_i, left_gap_i, right_gap_i);
          errors_o <= errors_o + 1;
        end else begin
          want = steer_q.pop_front();
          results_o <= results_o + 1;
          if (front_distance_i !== want.front || left_gap_i !== want.left ||
              right_gap_i !== want.right || linear_speed_i !== want.speed ||
              angular_rate_i !== want.turn) begin
            errors_o <= errors_o + 1;
          end
          if (front_distance_i !== want.front) begin
            $error("front_distance: expected %0d, got %0d", want.front, front_distance_i);
          end
          if (left_gap_i !== want.left) begin
            $error("left_gap: expected %0d, got %0d", want.left, left_gap_i);
          end
          if (right_gap_i !== want.right) begin
            $error("right_gap: expected %0d, got %0d", want.right, right_gap_i);
          end
          if (linear_speed_i !== want.speed) begin
            $error("linear_speed: expected %0d, got %0d", want.speed, linear_speed_i);
          end
          if (angular_rate_i !== want.turn) begin
            $error("angular_rate: expected %0d, got %0d", want.turn, angular_rate_i);
          end
        end
      end
      pending_o <= steer_q.size();
    end
  end

endmodule

### test/lidar_zone_steering_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the lidar zone steering block. A checker instance
// beside the block follows every accepted sample and predicts each scan result;
// this module only produces samples, register settings, output ready and the final verdict.
module lidar_zone_steering_test;
  import lzs_pkg::*;

  // The quiet period before a register write leaves room for samples still in the pipe.
  localparam int QuietCycles = 12;
  localparam int CycleLimit  = 200000;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_we_i       = 1'b0;
  logic [2:0]                cfg_idx_i      = 3'd0;
  logic [15:0]               cfg_wdata_i    = 16'd0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic [RangeW-1:0]         range_mm_i     = '0;
  logic                      last_of_scan_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic signed [FrontW-1:0]  front_distance_o;
  logic [SideW-1:0]          left_gap_o;
  logic [SideW-1:0]          right_gap_o;
  logic signed [SpeedW-1:0]  linear_speed_o;
  logic signed [TurnW-1:0]   angular_rate_o;

  int   errors;
  int   pending;
  int   results;
  int   cycles    = 0;
  int   n_samples = 0;
  int   n_scans   = 0;
  // While calm is set neither side of the block holds back.
  logic calm      = 1'b0;

  lidar_zone_steering DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .range_mm_i       (range_mm_i),
    .last_of_scan_i   (last_of_scan_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .front_distance_o (front_distance_o),
    .left_gap_o       (left_gap_o),
    .right_gap_o      (right_gap_o),
    .linear_speed_o   (linear_speed_o),
    .angular_rate_o   (angular_rate_o)
  );

  lidar_zone_steering_check u_steer_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .range_mm_i       (range_mm_i),
    .last_of_scan_i   (last_of_scan_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .front_distance_i (front_distance_o),
    .left_gap_i       (left_gap_o),
    .right_gap_i      (right_gap_o),
    .linear_speed_i   (linear_speed_o),
    .angular_rate_i   (angular_rate_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .results_o        (results)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // The receiver stalls about a third of the cycles unless the run is calm.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 33);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One item on the input channel, with a random gap ahead of it. Valid stays
  // up with the same payload until the block takes the item.
  task automatic send_item(input logic [RangeW-1:0] rng, input logic last);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    range_mm_i     <= rng;
    last_of_scan_i <= last;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    n_samples++;
    if (last) begin
      n_scans++;
    end
  endtask

  // The caller lowers the write enable after its last write, so a run of
  // writes keeps it high without a drop in between.
  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Stop sending and let every scan result come out, then give the pipe time
  // to absorb samples that close no scan.
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // The 10 bit registers get random bits above their width, which the block drops.
  task automatic apply_settings(input cfg_t s);
    write_reg(RegAngleStart, s.angle_start);
    write_reg(RegAngleStep, s.angle_step);
    write_reg(RegFrontHalfWdt, s.front_half_width);
    write_reg(RegSideMinFwd, s.side_min_forward);
    write_reg(RegSlowDistance, s.slow_distance);
    write_reg(RegStopOffset, s.stop_offset);
    write_reg(RegSlowGain, {6'($urandom_range(0, 63)), s.slow_gain});
    write_reg(RegTurnRate, {6'($urandom_range(0, 63)), s.turn_rate});
    cfg_we_i <= 1'b0;
  endtask

  // Ranges lean toward the short distances where the zone limits sit, with
  // the field extremes and the full span mixed in.
  function automatic logic [RangeW-1:0] pick_range();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return RangeW'($urandom_range(0, 65535));
      default: return RangeW'($urandom_range(0, 2500));
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.angle_start = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 4) == 0) begin
      s.angle_step = 16'($urandom_range(0, 65535));
    end else begin
      s.angle_step = 16'(65536 / $urandom_range(4, 64));
    end
    s.front_half_width = 16'($urandom_range(0, 1500));
    s.side_min_forward = 16'($urandom_range(0, 1500));
    s.slow_distance    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 3000));
    s.stop_offset      = 16'($urandom_range(0, 1000));
    s.slow_gain        = GainW'($urandom_range(0, 1023));
    s.turn_rate        = RateW'($urandom_range(0, 1000));
    return s;
  endfunction

  // Mostly complete scans of random length with random ranges. Now and then
  // the end-of-scan flag is flipped, so scans break early or run on, and the
  // last scan of a phase may be cut off by the next register settings.
  task automatic run_scans(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    logic        last;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      for (int i = 0; i < len && sent < items; i++) begin
        last = (i == len - 1);
        if ($urandom_range(0, 19) == 0) begin
          last = ~last;
        end
        send_item(pick_range(), last);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    cfg_t        s;
    int unsigned sweep[16];
    sweep = '{0, 65535, 300, 299, 301, 250, 251, 1, 65535, 1000, 5000, 32768, 100,
              65534, 2, 750};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset thresholds, sixteen samples per turn,
    // starting a quarter turn to the right.
    write_reg(RegAngleStart, 16'h4000);
    write_reg(RegAngleStep, 16'h1000);
    cfg_we_i <= 1'b0;

    // A scan whose points all lie right or behind and outside every zone:
    // all three distances read none and the turn goes negative.
    send_item(16'd65535, 1'b0);
    send_item(16'd400, 1'b0);
    send_item(16'd1000, 1'b1);

    // A full turn with the range extremes and values at the zone limits.
    foreach (sweep[i]) begin
      send_item(RangeW'(sweep[i]), i == 15);
    end

    // A one-sample scan: zero range straight right lands in the front zone.
    send_item(16'd0, 1'b1);

    // Restart the angle sequence in the middle of a scan. The sender waits
    // here until every scan result has come out.
    send_item(16'd2000, 1'b0);
    send_item(16'd65535, 1'b0);
    drain();
    write_reg(RegAngleStart, 16'h0000);
    cfg_we_i <= 1'b0;
    send_item(16'd800, 1'b0);
    send_item(16'd120, 1'b0);
    send_item(16'd3000, 1'b1);
    drain();

    // Every register at its low extreme.
    s = '{angle_start: 16'd0, angle_step: 16'd0, front_half_width: 16'd0,
          side_min_forward: 16'd0, slow_distance: 16'd0, stop_offset: 16'd0,
          slow_gain: '0, turn_rate: '0};
    apply_settings(s);
    run_scans(120);
    drain();

    // Everything at the top: the speed saturates low for points ahead.
    s = '{angle_start: 16'hFFFF, angle_step: 16'hFFFF, front_half_width: 16'hFFFF,
          side_min_forward: 16'hFFFF, slow_distance: 16'hFFFF, stop_offset: 16'hFFFF,
          slow_gain: '1, turn_rate: RateW'(1000)};
    apply_settings(s);
    run_scans(120);
    drain();

    // No stop offset and full gain: a far front reading saturates the speed high.
    s = '{angle_start: 16'h0000, angle_step: 16'h0800, front_half_width: 16'hFFFF,
          side_min_forward: 16'd0, slow_distance: 16'hFFFF, stop_offset: 16'd0,
          slow_gain: '1, turn_rate: RateW'(1000)};
    apply_settings(s);
    run_scans(120);
    drain();

    // Random register settings; one phase runs with both sides always ready.
    for (int p = 0; p < 7; p++) begin
      calm = (p == 3);
      apply_settings(random_settings());
      run_scans(130);
      drain();
    end
    calm = 1'b0;

    $display("Sent %0d samples, %0d flagged as scan ends; %0d scan results checked.",
             n_samples, n_scans, results);
    $display("Settings: reset values, both register extremes, high saturation, 7 random.");
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lzs_pkg.sv
hw/rtl/lzs_sine_rom.sv
hw/rtl/lzs_zone_track.sv
hw/rtl/lzs_steer.sv
hw/rtl/lidar_zone_steering.sv
test/lidar_zone_steering_check.sv
test/lidar_zone_steering_test.sv
